// ----- sv/sis_pkg.sv -----
// Shared types and codes for the sorted insert stack.
`default_nettype none
package sis_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // Status codes returned with each result word
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
    } sis_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/sis_cell.sv -----
// One storage cell of the sorted chain: compares, inserts and shifts.
`default_nettype none
module sis_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                    aclk,
    input  wire sis_pkg::sis_ctrl_t ctrl,
    input  wire                    occ,        // cell holds a live entry
    input  wire [DATA_WIDTH-1:0]   value,      // value being pushed
    input  wire                    prev_take,  // neighbor toward the top takes
    input  wire [DATA_WIDTH-1:0]   prev_data,  // neighbor toward the top
    input  wire [DATA_WIDTH-1:0]   next_data,  // neighbor toward the bottom
    output logic                   take,
    output logic [DATA_WIDTH-1:0]  data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Cell is at or below the insert point when it is free or not above the value
    assign take = !occ || ($signed(data_reg) <= $signed(value));
    assign data = data_reg;

    // Insert: shift down from the neighbor, or land the new value at the boundary.
    // Remove: pull up from the neighbor below.
    always_comb begin
        data_next = data_reg;
        if (ctrl.push) begin
            if (take) begin
                data_next = prev_take ? prev_data : value;
            end
        end else if (ctrl.pop) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ----- sv/sorted_insert_stack.sv -----
// Top level of the sorted insert stack: cell chain, fill count and result register.
`default_nettype none
// Sorted stack of up to DEPTH signed values kept in a chain of cells, largest
// value in cell 0. Each input word is a push, pop, peek or no-op chosen by s_tuser.
// Every cell compares its entry with the pushed value in parallel and either
// holds, takes its upper neighbor or takes the new value, so a push or pop
// completes in the cycle the word is accepted; the result word is loaded into
// an output register on acceptance. One word is taken per cycle
// while the result side keeps up; the critical path is one DATA_WIDTH-bit
// signed compare per cell plus the fan-out of the shift control to all cells.
// The occupancy of a result word reflects the state after the word, its status the state before.
module sorted_insert_stack #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int IN_W  = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int RES_W = DATA_WIDTH + sis_pkg::STATUS_W + CNT_W,
    localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire [IN_W-1:0]              s_tdata,   // [DATA_WIDTH-1:0] value, rest zero
    input  wire [sis_pkg::MODE_W-1:0]   s_tuser,   // [1:0] mode
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [OUT_W-1:0]            m_tdata    // result_value, status, occupancy, zero fill
);

    logic                  m_tvalid_reg;
    logic [RES_W-1:0]      res_reg;
    logic [RES_W-1:0]      res_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic                         accept;
    logic [sis_pkg::MODE_W-1:0]   mode;
    logic [DATA_WIDTH-1:0]        value;
    logic                         is_full;
    logic                         is_empty;
    sis_pkg::sis_ctrl_t           ctrl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                  cell_take [DEPTH];

    logic [DATA_WIDTH-1:0]          out_value;
    logic [sis_pkg::STATUS_W-1:0]   out_status;

    // Take a word whenever the result register is free or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign mode     = s_tuser;
    assign value    = s_tdata[DATA_WIDTH-1:0];
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Broadcast the shift command to the chain
    always_comb begin
        ctrl.push = accept && (mode == sis_pkg::MODE_PUSH) && !is_full;
        ctrl.pop  = accept && (mode == sis_pkg::MODE_POP) && !is_empty;
    end

    // Build the chain: cell 0 is the top of the stack
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                  p_take;
        logic [DATA_WIDTH-1:0] p_data;
        logic [DATA_WIDTH-1:0] n_data;

        if (i == 0) begin : g_top
            assign p_take = 1'b0;
            assign p_data = '0;
        end else begin : g_mid
            assign p_take = cell_take[i-1];
            assign p_data = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_bot
            assign n_data = cell_data[i];
        end else begin : g_nxt
            assign n_data = cell_data[i+1];
        end

        sis_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .occ      (CNT_W'(i) < count_reg),
            .value    (value),
            .prev_take(p_take),
            .prev_data(p_data),
            .next_data(n_data),
            .take     (cell_take[i]),
            .data     (cell_data[i])
        );
    end

    // Advance the fill count
    always_comb begin
        count_next = count_reg;
        if (ctrl.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Form the result word for the accepted operation
    always_comb begin
        out_value  = '0;
        out_status = sis_pkg::ST_OK;
        unique case (mode)
            sis_pkg::MODE_PUSH: begin
                if (is_full) begin
                    out_status = sis_pkg::ST_FULL;
                end
            end
            sis_pkg::MODE_POP, sis_pkg::MODE_PEEK: begin
                if (is_empty) begin
                    out_status = sis_pkg::ST_EMPTY;
                end else begin
                    out_value = cell_data[0];
                end
            end
            default: begin
                out_status = sis_pkg::ST_OK;
            end
        endcase
        res_next = {count_next, out_status, out_value};
    end

    // Hold control state; load the result register on acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(res_reg);

    // Fill count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above capacity");

    // A pop on a non-empty stack removes exactly one entry
    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not remove one entry");

    // The two top cells stay in descending order
    a_top_order: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_W'(2) |-> $signed(cell_data[0]) >= $signed(cell_data[1]))
        else $error("top cells out of order");

    // An empty or full status always carries a zero value
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (res_reg[DATA_WIDTH +: sis_pkg::STATUS_W] != sis_pkg::ST_OK))
            |-> res_reg[DATA_WIDTH-1:0] == '0)
        else $error("nonzero value with error status");

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the sorted insert stack: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;

    localparam int DEPTH       = 64;
    localparam int DATA_W      = 32;
    localparam int IN_W        = 32;
    localparam int OUT_W       = 48;
    localparam int RAND_ITEMS  = 1750;
    localparam int HOLD_CYCLES = 300;

    // Mode 3 is not an operation; the block answers it with status ok
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [1:0]        status;
        logic [6:0]        occ;
    } sis_result_t;

    typedef struct {
        logic [1:0]        mode;
        logic [DATA_W-1:0] value;
        int unsigned       reps;
        bit                randv;
        bit                typed;
        sis_result_t       res;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;    // [31:0] value
    logic [1:0]        s_tuser;    // [1:0] mode
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;    // [31:0] result_value, [33:32] status, [40:34] occupancy

    // Shadow copy of the sorted store and its fill count
    logic [DATA_W-1:0] shadow_stack [DEPTH];
    int unsigned       shadow_fill;

    sis_result_t       pending_results [$];
    int unsigned       mismatch_cnt;
    int unsigned       burst_left;
    bit                hold_req;

    // Directed table: typed results only where they follow at a glance
    stim_row_t stim_rows [24] = '{
        '{sis_pkg::MODE_POP,  32'h0000_0000, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_EMPTY, 7'd0}},
        '{sis_pkg::MODE_PEEK, 32'hFFFF_FFFF, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_EMPTY, 7'd0}},
        '{MODE_NONE, 32'hFFFF_FFFF, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_OK, 7'd0}},
        '{sis_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_OK, 7'd1}},
        '{sis_pkg::MODE_PUSH, 32'h8000_0000, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_OK, 7'd2}},
        '{sis_pkg::MODE_PEEK, 32'h0000_0000, 1, 1'b0, 1'b1,
          '{32'h7FFF_FFFF, sis_pkg::ST_OK, 7'd2}},
        '{sis_pkg::MODE_PUSH, 32'h0000_0005, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_OK, 7'd3}},
        '{sis_pkg::MODE_PUSH, 32'h0000_0005, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_OK, 7'd4}},
        '{sis_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_OK, 7'd5}},
        '{MODE_NONE, 32'h5A5A_5A5A, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_OK, 7'd5}},
        '{sis_pkg::MODE_POP,  32'h0000_0000, 1, 1'b0, 1'b1,
          '{32'h7FFF_FFFF, sis_pkg::ST_OK, 7'd4}},
        '{sis_pkg::MODE_POP,  32'hA5A5_A5A5, 1, 1'b0, 1'b1,
          '{32'h0000_0005, sis_pkg::ST_OK, 7'd3}},
        '{sis_pkg::MODE_PEEK, 32'h0000_0000, 1, 1'b0, 1'b1,
          '{32'h0000_0005, sis_pkg::ST_OK, 7'd3}},
        '{sis_pkg::MODE_POP,  32'h0000_0000, 1, 1'b0, 1'b1,
          '{32'h0000_0005, sis_pkg::ST_OK, 7'd2}},
        '{sis_pkg::MODE_POP,  32'h0000_0000, 1, 1'b0, 1'b1,
          '{32'hFFFF_FFFF, sis_pkg::ST_OK, 7'd1}},
        '{sis_pkg::MODE_POP,  32'h0000_0000, 1, 1'b0, 1'b1,
          '{32'h8000_0000, sis_pkg::ST_OK, 7'd0}},
        '{sis_pkg::MODE_POP,  32'h0000_0000, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_EMPTY, 7'd0}},
        '{sis_pkg::MODE_PUSH, 32'h0000_0000, 64, 1'b1, 1'b0, '{32'h0, sis_pkg::ST_OK, 7'd0}},
        '{sis_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_FULL, 7'd64}},
        '{sis_pkg::MODE_PUSH, 32'h8000_0000, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_FULL, 7'd64}},
        '{MODE_NONE, 32'h0000_0000, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_OK, 7'd64}},
        '{sis_pkg::MODE_PEEK, 32'h0000_0000, 1, 1'b0, 1'b0, '{32'h0, sis_pkg::ST_OK, 7'd0}},
        '{sis_pkg::MODE_POP,  32'h0000_0000, 64, 1'b1, 1'b0, '{32'h0, sis_pkg::ST_OK, 7'd0}},
        '{sis_pkg::MODE_POP,  32'h0000_0000, 1, 1'b0, 1'b1, '{32'h0, sis_pkg::ST_EMPTY, 7'd0}}
    };

    sorted_insert_stack #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one operation to the shadow stack and return the word it should produce
    function automatic sis_result_t apply_stack_op(logic [1:0] mode, logic [DATA_W-1:0] value);
        sis_result_t res;
        int unsigned pos;
        res = '{value: '0, status: sis_pkg::ST_OK, occ: '0};
        if (mode == sis_pkg::MODE_PUSH) begin
            if (shadow_fill >= DEPTH) begin
                res.status = sis_pkg::ST_FULL;
            end else begin
                // shift larger entries up; equal ones stay below the new value
                pos = shadow_fill;
                while (pos > 0 && $signed(shadow_stack[pos-1]) > $signed(value)) begin
                    shadow_stack[pos] = shadow_stack[pos-1];
                    pos--;
                end
                shadow_stack[pos] = value;
                shadow_fill++;
            end
        end else if (mode == sis_pkg::MODE_POP || mode == sis_pkg::MODE_PEEK) begin
            if (shadow_fill == 0) begin
                res.status = sis_pkg::ST_EMPTY;
            end else begin
                res.value = shadow_stack[shadow_fill-1];
                if (mode == sis_pkg::MODE_POP)
                    shadow_fill--;
            end
        end
        res.occ = shadow_fill[6:0];
        return res;
    endfunction

    // Mix small values for duplicates, extremes and full-range noise
    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 8) - 32'd4;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [1:0] pick_mode(int unsigned push_pct, int unsigned pop_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return MODE_NONE;
        if (roll < 3 + push_pct)
            return sis_pkg::MODE_PUSH;
        if (roll < 3 + push_pct + pop_pct)
            return sis_pkg::MODE_POP;
        return sis_pkg::MODE_PEEK;
    endfunction

    // Offer one word, in bursts with random gaps, and log its expected result
    task automatic send_word(logic [1:0] mode, logic [DATA_W-1:0] value, bit typed,
                             sis_result_t typed_res);
        sis_result_t res;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = apply_stack_op(mode, value);
        if (typed)
            res = typed_res;
        pending_results.push_back(res);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Stimulus: reset, directed table, then phased random traffic
    initial begin : stimulus
        sis_result_t no_res;
        int unsigned rand_sent;
        int unsigned phase_len;
        int unsigned push_pct;
        int unsigned pop_pct;
        int unsigned i;
        no_res       = '0;
        rand_sent    = 0;
        mismatch_cnt = 0;
        burst_left   = 0;
        hold_req     = 1'b0;
        shadow_fill  = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= sis_pkg::MODE_PUSH;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (stim_rows[r]) begin
            for (i = 0; i < stim_rows[r].reps; i++)
                send_word(stim_rows[r].mode,
                          stim_rows[r].randv ? rand_value() : stim_rows[r].value,
                          stim_rows[r].typed, stim_rows[r].res);
        end
        drain_results();

        while (rand_sent < RAND_ITEMS) begin
            // pick a fill, drain or mixed phase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    push_pct  = 85;
                    pop_pct   = 5;
                    phase_len = $urandom_range(70, 120);
                end
                4, 5, 6: begin
                    push_pct  = 10;
                    pop_pct   = 80;
                    phase_len = $urandom_range(30, 100);
                end
                default: begin
                    push_pct  = 45;
                    pop_pct   = 35;
                    phase_len = $urandom_range(20, 80);
                end
            endcase
            for (i = 0; i < phase_len && rand_sent < RAND_ITEMS; i++) begin
                if (rand_sent == 300)
                    hold_req = 1'b1;
                if (rand_sent == 1000)
                    drain_results();
                send_word(pick_mode(push_pct, pop_pct), rand_value(), 1'b0, no_res);
                rand_sent++;
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: stall on a pattern of its own, with one long hold-off on request
    initial begin : result_sink
        int unsigned style;
        int unsigned span;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(4, 40);
            repeat (span) begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
                @(posedge aclk);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin : check_result
        sis_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, m_tdata);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $display("%0t: result_value expected %h got %h",
                             $realtime, want.value, m_tdata[31:0]);
                    mismatch_cnt++;
                end
                if (m_tdata[33:32] !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $realtime, want.status, m_tdata[33:32]);
                    mismatch_cnt++;
                end
                if (m_tdata[40:34] !== want.occ) begin
                    $display("%0t: occupancy expected %0d got %0d",
                             $realtime, want.occ, m_tdata[40:34]);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
